// ===== hdl/bevmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bevmh_pkg
// Shared constants for the bird's-eye-view maximum height map.
// ----------------------------------------------------------------------------
package bevmh_pkg;

	localparam int GRID_MAX = 256;
	localparam int ROW_W    = $clog2(GRID_MAX);
	localparam int ADDR_W   = 2 * ROW_W;
	localparam int CELL_W   = 8;

	localparam int HALF_RANGE_W    = 8;
	localparam int SENSOR_HEIGHT_W = 12;
	localparam int CFG_DATA_W      = 12;
	localparam int CFG_INDEX_W     = 1;

	localparam logic [HALF_RANGE_W-1:0]    HALF_RANGE_RST    = 8'd112;
	localparam logic [SENSOR_HEIGHT_W-1:0] SENSOR_HEIGHT_RST = 12'd512;

	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_RANGE    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_HEIGHT = 1'b1;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	localparam int COORD_W = 24;

endpackage

// ===== hdl/bevmh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bevmh_if
// Handshake channels for point items and height results.
// ----------------------------------------------------------------------------
interface bevmh_point_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic signed [23:0] point_z;
	logic               is_ground;
	logic [7:0]         read_row;
	logic [7:0]         read_col;

	modport source (
		output valid, mode, point_x, point_y, point_z, is_ground, read_row, read_col,
		input  ready
	);
	modport sink (
		input  valid, mode, point_x, point_y, point_z, is_ground, read_row, read_col,
		output ready
	);
endinterface

interface bevmh_height_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_height;

	modport source (
		output valid, cell_height,
		input  ready
	);
	modport sink (
		input  valid, cell_height,
		output ready
	);
endinterface

// ===== hdl/bevmh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bevmh_ram
// Generic simple dual-port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bevmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/bev_max_height_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bev_max_height_map
// Rasterizes lidar points into a square grid that keeps the maximum height
// code per 1 m cell; a read item returns one cell and clears it.
// ----------------------------------------------------------------------------
// A read result passes stage 1, stage 2 and the output register in turn.
// Throughput: one item per cycle, set by the single read-modify-write pass on
// the grid RAM; a held result stalls the pipeline only behind a read item.
// Reset: a clearing pass writes zero to all 65536 cells, one per cycle, and no
// item is accepted during the pass; configuration writes are taken.
// ----------------------------------------------------------------------------
module bev_max_height_map (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bevmh_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bevmh_pkg::CFG_DATA_W-1:0]    cfg_data,
	bevmh_point_if.sink                         point_in,
	bevmh_height_if.source                      height_out
);

	localparam int ROW_W  = bevmh_pkg::ROW_W;
	localparam int ADDR_W = bevmh_pkg::ADDR_W;
	localparam int CELL_W = bevmh_pkg::CELL_W;
	localparam int CW     = bevmh_pkg::COORD_W;

	logic [bevmh_pkg::HALF_RANGE_W-1:0]    half_range_q;
	logic [bevmh_pkg::SENSOR_HEIGHT_W-1:0] sensor_height_q;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              s1_valid_q;
	logic              mode_s1;
	logic [CW-1:0]     px_s1;
	logic [CW-1:0]     py_s1;
	logic [CW-1:0]     pz_s1;
	logic              gnd_s1;
	logic [7:0]        rrow_s1;
	logic [7:0]        rcol_s1;

	logic [CW+1:0]     wx;
	logic [CW+1:0]     wy;
	logic [CW+1:0]     th;
	logic [8:0]        hr_p1;
	logic [17:0]       side_s;
	logic              x_ok;
	logic              y_ok;
	logic              rd_ok;
	logic [CELL_W-1:0] code;
	logic [ADDR_W-1:0] s1_addr;
	logic              s1_wr;

	logic              s2_valid_q;
	logic              read_s2;
	logic              wr_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [CELL_W-1:0] code_s2;
	logic              fwd_s2;
	logic [CELL_W-1:0] fwd_data_s2;

	logic [CELL_W-1:0] ram_rdata;
	logic [CELL_W-1:0] old_val;
	logic [CELL_W-1:0] s2_wdata;
	logic              stall;
	logic              adv;

	logic              out_valid_q;
	logic [CELL_W-1:0] cell_height_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_range_q    <= bevmh_pkg::HALF_RANGE_RST;
			sensor_height_q <= bevmh_pkg::SENSOR_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bevmh_pkg::CFG_HALF_RANGE: begin
					half_range_q <= cfg_data[bevmh_pkg::HALF_RANGE_W-1:0];
				end
				bevmh_pkg::CFG_SENSOR_HEIGHT: begin
					sensor_height_q <= cfg_data[bevmh_pkg::SENSOR_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign stall = s2_valid_q && read_s2 && out_valid_q && !height_out.ready;
	assign adv   = !stall;
	assign point_in.ready = !clr_busy_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= point_in.valid && point_in.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= point_in.mode;
			px_s1   <= point_in.point_x;
			py_s1   <= point_in.point_y;
			pz_s1   <= point_in.point_z;
			gnd_s1  <= point_in.is_ground;
			rrow_s1 <= point_in.read_row;
			rcol_s1 <= point_in.read_col;
		end
	end

	// Adding (half_range + 1) m folds the half meter offset and the rounding
	// into one sum; the cell index is then the integer part of a positive sum.
	always_comb begin
		hr_p1  = {1'b0, half_range_q} + 9'd1;
		wx     = {{2{px_s1[CW-1]}}, px_s1} + {9'b0, hr_p1, 8'h00};
		wy     = {{2{py_s1[CW-1]}}, py_s1} + {9'b0, hr_p1, 8'h00};
		side_s = {9'b0, half_range_q, 1'b0};
		if (side_s > 18'(bevmh_pkg::GRID_MAX)) begin
			side_s = 18'(bevmh_pkg::GRID_MAX);
		end
		x_ok  = !wx[CW+1] && (wx != '0) && (wx[CW+1:8] < side_s);
		y_ok  = !wy[CW+1] && (wy != '0) && (wy[CW+1:8] < side_s);
		rd_ok = (32'(rrow_s1) < bevmh_pkg::GRID_MAX) && (32'(rcol_s1) < bevmh_pkg::GRID_MAX);

		th = {{2{pz_s1[CW-1]}}, pz_s1} + {14'b0, sensor_height_q};
		if (th[CW+1]) begin
			code = '0;
		end else if (|th[CW+1:14]) begin
			code = '1;
		end else begin
			code = th[13:6];
		end

		if (mode_s1 == bevmh_pkg::MODE_READ) begin
			s1_addr = {ROW_W'(rrow_s1), ROW_W'(rcol_s1)};
			s1_wr   = rd_ok;
		end else begin
			s1_addr = {wx[8+ROW_W-1:8], wy[8+ROW_W-1:8]};
			s1_wr   = !gnd_s1 && x_ok && y_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_s2     <= (mode_s1 == bevmh_pkg::MODE_READ);
			wr_s2       <= s1_wr;
			addr_s2     <= s1_addr;
			code_s2     <= code;
			fwd_s2      <= s2_valid_q && wr_s2 && (addr_s2 == s1_addr);
			fwd_data_s2 <= s2_wdata;
		end
	end

	always_comb begin
		old_val = fwd_s2 ? fwd_data_s2 : ram_rdata;
		if (read_s2) begin
			s2_wdata = '0;
		end else if (old_val > code_s2) begin
			s2_wdata = old_val;
		end else begin
			s2_wdata = code_s2;
		end
	end

	assign ram_re    = adv && s1_valid_q;
	assign ram_we    = clr_busy_q || (adv && s2_valid_q && wr_s2);
	assign ram_waddr = clr_busy_q ? clr_cnt_q : addr_s2;
	assign ram_wdata = clr_busy_q ? '0 : s2_wdata;

	bevmh_ram #(
		.WIDTH (CELL_W),
		.DEPTH (bevmh_pkg::GRID_MAX * bevmh_pkg::GRID_MAX)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (s1_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s2_valid_q && read_s2) begin
			out_valid_q <= 1'b1;
		end else if (height_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_valid_q && read_s2) begin
			cell_height_q <= wr_s2 ? old_val : '0;
		end
	end

	assign height_out.valid       = out_valid_q;
	assign height_out.cell_height = cell_height_q;

`ifndef SYNTHESIS
	a_no_items_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!s1_valid_q && !s2_valid_q))
		else $error("pipeline holds an item during the clearing pass");

	a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !adv) |=> (s2_valid_q && $stable(addr_s2)))
		else $error("stage 2 item changed while stalled");

	a_clear_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> ($past(clr_cnt_q) == '1))
		else $error("clearing pass ended before the last cell");
`endif

endmodule
